// ----- hdl/pts_pkg.sv -----
// Shared constants, codes and types of the priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

   // Default table size and tick counter width.
   localparam int DEFAULT_MAX_TASKS  = 8;
   localparam int DEFAULT_TICK_WIDTH = 32;

   // A task slot number is held in enough bits for the largest table (64 entries).
   localparam int SLOT_W = 6;
   localparam int PRIO_W = 7;
   localparam int ACT_W  = 3;
   localparam int STAT_W = 2;

   // Event codes.
   localparam logic [ACT_W-1:0] ACT_CREATE   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELAY    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SUSPEND  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_ACTIVATE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_TICK     = 3'd4;

   // Task status codes.
   localparam logic [STAT_W-1:0] ST_READY     = 2'd0;
   localparam logic [STAT_W-1:0] ST_RUNNING   = 2'd1;
   localparam logic [STAT_W-1:0] ST_WAITING   = 2'd2;
   localparam logic [STAT_W-1:0] ST_SUSPENDED = 2'd3;

   // Write and tick command broadcast to every cell of the task row.
   typedef struct packed {
      logic                wr_en;
      logic [SLOT_W-1:0]   slot;
      logic                set_prio;
      logic [PRIO_W-1:0]   prio;
      logic                set_status;
      logic [STAT_W-1:0]   status;
      logic                load_wait;
      logic                tick;
   } cell_cmd_type;

   // Dispatch scan token handed from cell to cell.
   typedef struct packed {
      logic                valid;
      logic                found;
      logic [PRIO_W-1:0]   prio;
      logic [SLOT_W-1:0]   slot;
   } scan_type;

endpackage

`default_nettype wire

// ----- hdl/pts_cell.sv -----
// One task entry of the scheduler row, with its stage of the dispatch scan.
`timescale 1ns / 1ps
`default_nettype none

module pts_cell #(
   parameter int INDEX      = 0,
   parameter int TICK_WIDTH = pts_pkg::DEFAULT_TICK_WIDTH,
   parameter int CNT_W      = 4
) (
   input  wire                          clock,
   input  wire                          reset,
   input  pts_pkg::cell_cmd_type        cmd,
   input  wire  [TICK_WIDTH-1:0]        wait_value,
   input  wire  [CNT_W-1:0]             task_count,
   input  pts_pkg::scan_type            scan_in,
   output pts_pkg::scan_type            scan_out
);

   logic [pts_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic [pts_pkg::STAT_W-1:0] status_ff, status_in;
   logic [TICK_WIDTH-1:0]      wait_ff, wait_in;
   logic [TICK_WIDTH-1:0]      wait_dec;
   pts_pkg::scan_type          scan_ff, scan_in_next;
   logic                       used;
   logic                       hit;
   logic                       eligible;
   logic                       take;

   // The entry exists once the task count has passed this slot.
   assign used     = task_count > CNT_W'(INDEX);
   assign hit      = cmd.wr_en && (cmd.slot == pts_pkg::SLOT_W'(INDEX));
   assign wait_dec = wait_ff - TICK_WIDTH'(1);

   // Entry update: a direct write, or a countdown step on a tick.
   always_comb begin
      prio_in   = prio_ff;
      status_in = status_ff;
      wait_in   = wait_ff;
      if (hit) begin
         if (cmd.set_prio) begin
            prio_in = cmd.prio;
         end
         if (cmd.set_status) begin
            status_in = cmd.status;
         end
         if (cmd.load_wait) begin
            wait_in = wait_value;
         end
      end else if (cmd.tick && used && (status_ff == pts_pkg::ST_WAITING)) begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            status_in = pts_pkg::ST_READY;
         end
      end
   end

   // Scan stage: a ready or running entry of strictly higher priority takes the token.
   assign eligible = used && ((status_ff == pts_pkg::ST_READY) ||
                              (status_ff == pts_pkg::ST_RUNNING));
   assign take     = scan_in.valid && eligible && (!scan_in.found || (prio_ff > scan_in.prio));

   always_comb begin
      scan_in_next = scan_in;
      if (take) begin
         scan_in_next.found = 1'b1;
         scan_in_next.prio  = prio_ff;
         scan_in_next.slot  = pts_pkg::SLOT_W'(INDEX);
      end
   end

   // Entry storage is written by create before any read, so it has no reset.
   always_ff @(posedge clock) begin
      prio_ff   <= prio_in;
      status_ff <= status_in;
      wait_ff   <= wait_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.valid <= 1'b0;
      end else begin
         scan_ff <= scan_in_next;
      end
   end

   assign scan_out = scan_ff;

endmodule

`default_nettype wire

// ----- hdl/priority_task_scheduler_core.sv -----
// Top level of the fixed-priority task scheduler: event sequencer and the row of task cells.
//
// Usage:
//   req channel: one beat per scheduler event (create, delay, suspend, activate, tick).
//   rsp channel: exactly one beat per event with the current task, the switch flag,
//   the create status and handle, and the global tick count.
//   A create, or an event that is ignored, goes from idle straight to the commit step.
//   Events that dispatch run a scan token through the row of MAX_TASKS cells, one cell
//   per cycle, and pass to the commit step once the token leaves the last cell.
//   One event is in work at a time; req_tready is high while the sequencer is idle,
//   so the next beat is taken only after the current event has left the commit step.
//   The result sits in an output register; a new event is accepted while it waits.
//   If rsp_tready is low, the next event finishes its work and then holds in the
//   commit step until the output register is free.
//   Reset empties the task table, clears the current task and the tick counter, and
//   drops rsp_tvalid. Table entries hold no value until a create writes them.
`timescale 1ns / 1ps
`default_nettype none

module priority_task_scheduler_core #(
   parameter int MAX_TASKS  = pts_pkg::DEFAULT_MAX_TASKS,
   parameter int TICK_WIDTH = pts_pkg::DEFAULT_TICK_WIDTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [2:0] action, [9:3] priority_req, [10] start_suspended, [13:11] task_index,
   // [45:14] delay_ticks, [47:46] zero
   input  wire  [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] running_valid, [3:1] running_task, [4] switched, [5] create_ok,
   // [8:6] new_handle, [40:9] tick_count, [47:41] zero
   output logic [47:0] rsp_tdata
);

   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int SLOT_W = pts_pkg::SLOT_W;

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   // Request fields.
   logic [pts_pkg::ACT_W-1:0]  req_action;
   logic [pts_pkg::PRIO_W-1:0] req_priority;
   logic                       req_suspended;
   logic [2:0]                 req_index;
   logic [31:0]                req_delay;

   assign req_action    = req_tdata[2:0];
   assign req_priority  = req_tdata[9:3];
   assign req_suspended = req_tdata[10];
   assign req_index     = req_tdata[13:11];
   assign req_delay     = req_tdata[45:14];

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic [TICK_WIDTH-1:0] ticks_ff, ticks_in;
   logic                  dispatch_ff, dispatch_in;
   logic                  inject_ff, inject_in;
   logic                  ok_ff, ok_in;
   logic [SLOT_W-1:0]     handle_ff, handle_in;
   logic                  best_found_ff, best_found_in;
   logic [SLOT_W-1:0]     best_slot_ff, best_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [47:0]           rsp_data_ff, rsp_data_in;

   pts_pkg::cell_cmd_type cmd;
   logic [TICK_WIDTH-1:0] wait_value;
   pts_pkg::scan_type     scan_link [0:MAX_TASKS];

   logic                  accept;
   logic                  out_free;
   logic                  sw;
   logic                  new_valid;
   logic [SLOT_W-1:0]     new_slot;
   logic [TICK_WIDTH+31:0] delay_ext;
   logic [TICK_WIDTH+31:0] ticks_ext;
   logic [CNT_W+2:0]      index_ext;
   logic [CNT_W+2:0]      count_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Width adaptation of the fixed 32-bit and 3-bit fields.
   assign delay_ext = {{TICK_WIDTH{1'b0}}, req_delay};
   assign ticks_ext = {32'd0, ticks_ff};
   assign index_ext = {{CNT_W{1'b0}}, req_index};
   assign count_ext = {3'b000, count_ff};

   // Switch decision once the scan result is in hand.
   always_comb begin
      sw = dispatch_ff && !((best_found_ff == cur_valid_ff) &&
                            (!best_found_ff || (best_slot_ff == cur_slot_ff)));
      new_valid = sw ? best_found_ff : cur_valid_ff;
      new_slot  = sw ? (best_found_ff ? best_slot_ff : '0) : cur_slot_ff;
   end

   // Event sequencer and cell command generation.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_valid_in  = cur_valid_ff;
      cur_slot_in   = cur_slot_ff;
      ticks_in      = ticks_ff;
      dispatch_in   = dispatch_ff;
      inject_in     = 1'b0;
      ok_in         = ok_ff;
      handle_in     = handle_ff;
      best_found_in = best_found_ff;
      best_slot_in  = best_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      cmd           = '0;
      wait_value    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dispatch_in = 1'b0;
               ok_in       = 1'b0;
               handle_in   = '0;
               case (req_action)
                  pts_pkg::ACT_CREATE: begin
                     if (count_ff < CNT_W'(MAX_TASKS)) begin
                        cmd.wr_en      = 1'b1;
                        cmd.slot       = SLOT_W'(count_ff);
                        cmd.set_prio   = 1'b1;
                        cmd.prio       = req_priority;
                        cmd.set_status = 1'b1;
                        cmd.status     = req_suspended ? pts_pkg::ST_SUSPENDED
                                                       : pts_pkg::ST_READY;
                        cmd.load_wait  = 1'b1;
                        ok_in          = 1'b1;
                        handle_in      = SLOT_W'(count_ff);
                        count_in       = count_ff + CNT_W'(1);
                     end
                  end
                  pts_pkg::ACT_DELAY: begin
                     if (cur_valid_ff) begin
                        cmd.wr_en      = 1'b1;
                        cmd.slot       = cur_slot_ff;
                        cmd.set_status = 1'b1;
                        cmd.status     = pts_pkg::ST_WAITING;
                        cmd.load_wait  = 1'b1;
                        wait_value     = delay_ext[TICK_WIDTH-1:0];
                        dispatch_in    = 1'b1;
                     end
                  end
                  pts_pkg::ACT_SUSPEND: begin
                     if (cur_valid_ff) begin
                        cmd.wr_en      = 1'b1;
                        cmd.slot       = cur_slot_ff;
                        cmd.set_status = 1'b1;
                        cmd.status     = pts_pkg::ST_SUSPENDED;
                        dispatch_in    = 1'b1;
                     end
                  end
                  pts_pkg::ACT_ACTIVATE: begin
                     if (index_ext < count_ext) begin
                        cmd.wr_en      = 1'b1;
                        cmd.slot       = SLOT_W'(req_index);
                        cmd.set_status = 1'b1;
                        cmd.status     = pts_pkg::ST_READY;
                        dispatch_in    = 1'b1;
                     end
                  end
                  pts_pkg::ACT_TICK: begin
                     ticks_in    = ticks_ff + TICK_WIDTH'(1);
                     cmd.tick    = 1'b1;
                     dispatch_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (dispatch_in) begin
                  inject_in = 1'b1;
                  state_in  = S_SCAN;
               end else begin
                  state_in  = S_COMMIT;
               end
            end
         end
         S_SCAN: begin
            // Wait for the token to leave the last cell.
            if (scan_link[MAX_TASKS].valid) begin
               best_found_in = scan_link[MAX_TASKS].found;
               best_slot_in  = scan_link[MAX_TASKS].slot;
               state_in      = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cur_valid_in = new_valid;
               cur_slot_in  = new_slot;
               if (sw && best_found_ff) begin
                  cmd.wr_en      = 1'b1;
                  cmd.slot       = best_slot_ff;
                  cmd.set_status = 1'b1;
                  cmd.status     = pts_pkg::ST_RUNNING;
               end
               rsp_data_in  = {7'd0, ticks_ext[31:0], handle_ff[2:0], ok_ff, sw,
                               new_slot[2:0], new_valid};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Scan token entering the first cell.
   assign scan_link[0] = {inject_ff, 1'b0, {pts_pkg::PRIO_W{1'b0}}, {SLOT_W{1'b0}}};

   // Row of task cells, each passing the scan token to the next.
   for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
      pts_cell #(
         .INDEX      (k),
         .TICK_WIDTH (TICK_WIDTH),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .wait_value (wait_value),
         .task_count (count_ff),
         .scan_in    (scan_link[k]),
         .scan_out   (scan_link[k+1])
      );
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
         ticks_ff     <= '0;
         dispatch_ff  <= 1'b0;
         inject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_valid_ff <= cur_valid_in;
         cur_slot_ff  <= cur_slot_in;
         ticks_ff     <= ticks_in;
         dispatch_ff  <= dispatch_in;
         inject_ff    <= inject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ok_ff         <= ok_in;
      handle_ff     <= handle_in;
      best_found_ff <= best_found_in;
      best_slot_ff  <= best_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
